[hw/rtl/sd_card_spi_slave_assert.svh]
// Assertion macros for the checker file of the SD card SPI block.
// No dependencies; included by bare file name.
`ifndef SD_CARD_SPI_SLAVE_ASSERT_SVH
`define SD_CARD_SPI_SLAVE_ASSERT_SVH

// Checked outside reset only.
`define SDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define SDS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/sds_pkg.sv]
// Constants for the SD card SPI-mode block: store geometry and command opcodes.
// No dependencies.
`default_nettype none

package sds_pkg;

  localparam int STORE_BYTES  = 32768;
  localparam int SECTOR_BYTES = 512;
  localparam int POS_W        = $clog2(STORE_BYTES);
  localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
  localparam int SEC_IDX_W    = POS_W - SECTOR_SHIFT;
  localparam int SECTOR_LIMIT = STORE_BYTES / SECTOR_BYTES;
  localparam int BLK_W        = $clog2(SECTOR_BYTES);
  localparam int STATUS_W     = 32;

  localparam logic [7:0] OP_GO_IDLE  = 8'h40;
  localparam logic [7:0] OP_IF_COND  = 8'h48;
  localparam logic [7:0] OP_APP_CMD  = 8'h77;
  localparam logic [7:0] OP_OP_COND  = 8'h69;
  localparam logic [7:0] OP_RD_BLOCK = 8'h51;
  localparam logic [7:0] OP_WR_BLOCK = 8'h58;

  localparam logic [7:0] R1_IDLE     = 8'h01;
  localparam logic [7:0] R1_READY    = 8'h00;
  localparam logic [7:0] TOKEN_START = 8'hfe;
  localparam logic [7:0] DATA_ACCEPT = 8'h05;
  localparam logic [7:0] BYTE_IDLE   = 8'hff;

endpackage

`default_nettype wire

[hw/rtl/sds_in_if.sv]
// Bus event channel into the SD card SPI block: valid/ready and the event fields.
// No dependencies.
`default_nettype none

interface sds_in_if;
  logic valid;
  logic ready;
  logic operation;
  logic level;
  logic mosi;

  modport source (output valid, output operation, output level, output mosi, input ready);
  modport sink   (input valid, input operation, input level, input mosi, output ready);
endinterface

`default_nettype wire

[hw/rtl/sds_out_if.sv]
// Result channel out of the SD card SPI block: valid/ready and the miso level.
// No dependencies.
`default_nettype none

interface sds_out_if;
  logic valid;
  logic ready;
  logic miso;

  modport source (output valid, output miso, input ready);
  modport sink   (input valid, input miso, output ready);
endinterface

`default_nettype wire

[hw/rtl/sd_card_spi_slave.sv]
// SD card in SPI mode, one bus event per transfer. Depends on sds_pkg, sds_in_if, sds_out_if.
// Path: an accepted event goes through the input register / next-state logic / result register;
// one event per cycle sustained while the result is taken (a stalled result holds the input).
// The byte store is read at the next position (pos_nxt) into a register, so reads never stall.
// Reset (rst_n low, synchronous) clears control state, then a pass over every address
// zeroes the byte store while in_ch.ready stays low; cfg writes are taken whenever rst_n is high.
`default_nettype none

module sd_card_spi_slave (
  input  wire logic        clk,
  input  wire logic        rst_n,
  sds_in_if.sink           in_ch,
  sds_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);

  localparam int POS_W = sds_pkg::POS_W;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(sds_pkg::STORE_BYTES - 1);
  localparam logic [sds_pkg::BLK_W-1:0] BLK_LAST =
    sds_pkg::BLK_W'(sds_pkg::SECTOR_BYTES - 1);

  localparam logic [3:0] MODE_CMD_IN    = 4'd0;
  localparam logic [3:0] MODE_RESET_ACK = 4'd1;
  localparam logic [3:0] MODE_IF_COND   = 4'd2;
  localparam logic [3:0] MODE_STATUS    = 4'd3;
  localparam logic [3:0] MODE_APP_CMD   = 4'd4;
  localparam logic [3:0] MODE_OP_COND   = 4'd5;
  localparam logic [3:0] MODE_RD_ACK    = 4'd6;
  localparam logic [3:0] MODE_RD_TOKEN  = 4'd7;
  localparam logic [3:0] MODE_RD_DATA   = 4'd8;
  localparam logic [3:0] MODE_WR_ACK    = 4'd9;
  localparam logic [3:0] MODE_WR_TOKEN  = 4'd10;
  localparam logic [3:0] MODE_WR_DATA   = 4'd11;
  localparam logic [3:0] MODE_WR_DONE   = 4'd12;

  // Configuration
  logic [sds_pkg::STATUS_W-1:0] status_r;

  // Store clearing pass
  logic             clr_r;
  logic [POS_W-1:0] clr_addr_r;

  // Input and result registers
  logic s1_valid_r, s1_op_r, s1_level_r, s1_mosi_r;
  logic out_valid_r, out_miso_r;
  logic out_free, fire, in_take;

  // Card state
  logic [3:0]                mode_r, mode_nxt;
  logic                      sel_high_r, sel_high_nxt;
  logic                      miso_r, miso_nxt;
  logic [5:0]                bit_cnt_r, bit_cnt_nxt;
  logic [7:0]                shift_r, shift_nxt;
  logic [7:0]                cmd_r [5];
  logic [7:0]                cmd_nxt [5];
  logic [2:0]                cmd_idx_r, cmd_idx_nxt;
  logic [7:0]                resp_r, resp_nxt;
  logic [sds_pkg::BLK_W-1:0] blk_cnt_r, blk_cnt_nxt;
  logic [POS_W-1:0]          pos_r, pos_nxt;

  // Byte store
  logic [7:0] store_mem [sds_pkg::STORE_BYTES];
  logic [7:0] rd_data_r;
  logic       wr_en;
  logic [7:0] wr_byte;

  // Shared per-event helpers
  logic [5:0]  bit_inc;
  logic        byte_done;
  logic [7:0]  shifted;
  logic        resp_bit;
  logic [31:0] sector;
  logic [POS_W-1:0] sector_pos;
  logic [POS_W-1:0] pos_adv;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign fire         = s1_valid_r && out_free;
  assign in_ch.ready  = !clr_r && (!s1_valid_r || out_free);
  assign in_take      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.miso  = out_miso_r;

  assign bit_inc    = bit_cnt_r + 6'd1;
  assign byte_done  = bit_inc >= 6'd8;
  assign shifted    = {shift_r[6:0], s1_mosi_r};
  assign resp_bit   = resp_r[3'd7 - bit_cnt_r[2:0]];
  assign sector     = {cmd_r[1], cmd_r[2], cmd_r[3], cmd_r[4]};
  assign sector_pos = (sector >= 32'(sds_pkg::SECTOR_LIMIT)) ? POS_LAST :
                      (POS_W'(sector[sds_pkg::SEC_IDX_W-1:0]) << sds_pkg::SECTOR_SHIFT);
  assign pos_adv    = (pos_r != POS_LAST) ? pos_r + POS_W'(1) : pos_r;

  always_comb begin
    mode_nxt     = mode_r;
    sel_high_nxt = sel_high_r;
    miso_nxt     = miso_r;
    bit_cnt_nxt  = bit_cnt_r;
    shift_nxt    = shift_r;
    cmd_nxt      = cmd_r;
    cmd_idx_nxt  = cmd_idx_r;
    resp_nxt     = resp_r;
    blk_cnt_nxt  = blk_cnt_r;
    pos_nxt      = pos_r;
    wr_en        = 1'b0;
    wr_byte      = shifted;

    if (fire) begin
      if (!s1_op_r) begin
        sel_high_nxt = s1_level_r;
        if (s1_level_r && mode_r == MODE_RD_DATA) begin
          mode_nxt = MODE_CMD_IN;
        end
      end else if (!sel_high_r && s1_level_r) begin
        // rising SCK while selected
        case (mode_r)
          MODE_RD_ACK, MODE_RD_TOKEN, MODE_WR_ACK, MODE_WR_DONE,
          MODE_RESET_ACK, MODE_APP_CMD, MODE_OP_COND, MODE_IF_COND: begin
            miso_nxt    = resp_bit;
            bit_cnt_nxt = byte_done ? 6'd0 : bit_inc;
            if (byte_done) begin
              case (mode_r)
                MODE_RD_ACK: begin
                  mode_nxt = MODE_RD_TOKEN;
                  resp_nxt = sds_pkg::TOKEN_START;
                end
                MODE_RD_TOKEN: mode_nxt = MODE_RD_DATA;
                MODE_WR_ACK:   mode_nxt = MODE_WR_TOKEN;
                MODE_WR_DONE: begin
                  mode_nxt = MODE_RESET_ACK;
                  resp_nxt = sds_pkg::BYTE_IDLE;
                end
                MODE_IF_COND:  mode_nxt = MODE_STATUS;
                default:       mode_nxt = MODE_CMD_IN;
              endcase
            end
          end
          MODE_WR_TOKEN: begin
            shift_nxt   = shifted;
            bit_cnt_nxt = byte_done ? 6'd0 : bit_inc;
            if (byte_done) begin
              mode_nxt    = MODE_WR_DATA;
              shift_nxt   = 8'd0;
              blk_cnt_nxt = '0;
            end
          end
          MODE_STATUS: begin
            // status word goes out LSB first
            miso_nxt    = status_r[bit_cnt_r[4:0]];
            bit_cnt_nxt = bit_inc;
            if (bit_inc >= 6'd32) begin
              bit_cnt_nxt = 6'd0;
              mode_nxt    = MODE_CMD_IN;
            end
          end
          MODE_RD_DATA: begin
            miso_nxt    = rd_data_r[3'd7 - bit_cnt_r[2:0]];
            bit_cnt_nxt = byte_done ? 6'd0 : bit_inc;
            if (byte_done) begin
              pos_nxt = pos_adv;
            end
          end
          MODE_WR_DATA: begin
            shift_nxt   = shifted;
            bit_cnt_nxt = byte_done ? 6'd0 : bit_inc;
            if (byte_done) begin
              wr_en       = 1'b1;
              pos_nxt     = pos_adv;
              shift_nxt   = 8'd0;
              blk_cnt_nxt = blk_cnt_r + sds_pkg::BLK_W'(1);
              if (blk_cnt_r == BLK_LAST) begin
                resp_nxt    = sds_pkg::DATA_ACCEPT;
                mode_nxt    = MODE_WR_DONE;
                blk_cnt_nxt = '0;
              end
            end
          end
          default: begin
            // command mode: six bytes, CRC byte is dropped
            shift_nxt   = shifted;
            bit_cnt_nxt = byte_done ? 6'd0 : bit_inc;
            if (byte_done) begin
              shift_nxt = 8'd0;
              if (cmd_idx_r == 3'd5) begin
                cmd_idx_nxt = 3'd0;
                case (cmd_r[0])
                  sds_pkg::OP_GO_IDLE: begin
                    mode_nxt = MODE_RESET_ACK;
                    resp_nxt = sds_pkg::R1_IDLE;
                  end
                  sds_pkg::OP_IF_COND: begin
                    mode_nxt = MODE_IF_COND;
                    resp_nxt = sds_pkg::R1_IDLE;
                  end
                  sds_pkg::OP_APP_CMD: begin
                    mode_nxt = MODE_APP_CMD;
                    resp_nxt = sds_pkg::R1_IDLE;
                  end
                  sds_pkg::OP_OP_COND: begin
                    mode_nxt = MODE_OP_COND;
                    resp_nxt = sds_pkg::R1_READY;
                  end
                  sds_pkg::OP_RD_BLOCK: begin
                    mode_nxt = MODE_RD_ACK;
                    resp_nxt = sds_pkg::R1_READY;
                    pos_nxt  = sector_pos;
                  end
                  sds_pkg::OP_WR_BLOCK: begin
                    mode_nxt = MODE_WR_ACK;
                    resp_nxt = sds_pkg::R1_READY;
                    pos_nxt  = sector_pos;
                  end
                  default: ;
                endcase
              end else begin
                cmd_nxt[cmd_idx_r] = shifted;
                cmd_idx_nxt        = cmd_idx_r + 3'd1;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r    <= '0;
      clr_r       <= 1'b1;
      clr_addr_r  <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_CMD_IN;
      sel_high_r  <= 1'b1;
      miso_r      <= 1'b0;
      bit_cnt_r   <= '0;
      shift_r     <= '0;
      for (int i = 0; i < 5; i++) begin
        cmd_r[i] <= '0;
      end
      cmd_idx_r   <= '0;
      resp_r      <= '0;
      blk_cnt_r   <= '0;
      pos_r       <= '0;
    end else begin
      if (cfg_we) begin
        status_r <= cfg_wdata;
      end
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + POS_W'(1);
        if (clr_addr_r == POS_LAST) begin
          clr_r <= 1'b0;
        end
      end
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      mode_r     <= mode_nxt;
      sel_high_r <= sel_high_nxt;
      miso_r     <= miso_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      shift_r    <= shift_nxt;
      cmd_r      <= cmd_nxt;
      cmd_idx_r  <= cmd_idx_nxt;
      resp_r     <= resp_nxt;
      blk_cnt_r  <= blk_cnt_nxt;
      pos_r      <= pos_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r    <= in_ch.operation;
      s1_level_r <= in_ch.level;
      s1_mosi_r  <= in_ch.mosi;
    end
    if (fire) begin
      out_miso_r <= miso_nxt;
    end
  end

  // Byte store: registered read at the next position
  always_ff @(posedge clk) begin
    if (clr_r) begin
      store_mem[clr_addr_r] <= 8'd0;
    end else if (wr_en) begin
      store_mem[pos_r] <= wr_byte;
    end
    rd_data_r <= store_mem[pos_nxt];
  end

endmodule

`default_nettype wire

[hw/rtl/sds_checker.sv]
// Port-level checks for sd_card_spi_slave, attached by the bind at the end.
// Depends on sd_card_spi_slave_assert.svh.
`default_nettype none

`include "sd_card_spi_slave_assert.svh"

module sds_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_miso
);

  // a result waiting for the sink holds
  `SDS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `SDS_ASSERT(a_miso_hold, out_valid && !out_ready |=> $stable(out_miso), "miso changed while stalled")
  // reset starts the store clearing pass, no transfer is taken
  `SDS_ASSERT_RST(a_rst_busy, !rst_n |=> !in_ready, "input ready during store clear")
  `SDS_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "result valid after reset")
  // no result is valid just after reset, before any item can be taken
  `SDS_ASSERT(a_no_spurious, $past(!rst_n) |-> !out_valid, "result without a transfer")

endmodule

bind sd_card_spi_slave sds_checker u_sds_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_miso  (out_ch.miso)
);

`default_nettype wire
